@@ rtl/mec_pkg.sv @@
// ----------------------------------------------------------------------------
// mec_pkg
// Event codes, register indexes and reset values for the motion event
// classifier.
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int unsigned THRESH_W   = 16;
    localparam int unsigned YAW_GATE_W = 15;
    localparam int unsigned ACCEL_W    = 17;
    localparam int unsigned YAW_W      = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_BRAKE        = 3'd1,
        EV_BUMP         = 3'd2,
        EV_CORNER_RIGHT = 3'd3,
        EV_CORNER_LEFT  = 3'd4,
        EV_ACCEL        = 3'd5
    } event_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRAKE       = 3'd0,
        REG_HARD_BRAKE  = 3'd1,
        REG_BUMP        = 3'd2,
        REG_CORNER      = 3'd3,
        REG_HARD_CORNER = 3'd4,
        REG_YAW_GATE    = 3'd5,
        REG_ACCEL       = 3'd6,
        REG_COOLDOWN    = 3'd7
    } cfg_index_t;

    localparam logic [THRESH_W-1:0]   BRAKE_RST       = 16'd1434;
    localparam logic [THRESH_W-1:0]   HARD_BRAKE_RST  = 16'd2048;
    localparam logic [THRESH_W-1:0]   BUMP_RST        = 16'd2048;
    localparam logic [THRESH_W-1:0]   CORNER_RST      = 16'd1434;
    localparam logic [THRESH_W-1:0]   HARD_CORNER_RST = 16'd2048;
    localparam logic [YAW_GATE_W-1:0] YAW_GATE_RST    = 15'd160;
    localparam logic [THRESH_W-1:0]   ACCEL_RST       = 16'd1229;
    localparam logic [THRESH_W-1:0]   COOLDOWN_RST    = 16'd1500;

    localparam logic [COUNT_W-1:0]    COUNT_MAX       = '1;

endpackage

@@ rtl/motion_event_classifier.sv @@
// ----------------------------------------------------------------------------
// motion_event_classifier
// Classifies one car-frame motion sample per transaction into an event code
// and keeps saturating hard-brake and hard-corner counts.
// ----------------------------------------------------------------------------
// One sample is taken per clock while in_stall is low. A sample is captured in
// an input register, judged against the thresholds and per-event cooldown
// timestamps in a single combinational pass, and its result lands in the
// output register once that register is free, raising out_valid. Event state is
// updated as the sample moves into the output register, which keeps back to
// back samples exact. Throughput is one transaction per cycle while out_stall
// is low; the input side keeps accepting while a result waits as long as the
// input register is free.
module motion_event_classifier
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mec_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [mec_pkg::ACCEL_W-1:0]  fwd_accel,
    input  logic signed [mec_pkg::ACCEL_W-1:0]  lat_accel,
    input  logic signed [mec_pkg::ACCEL_W-1:0]  vert_accel,
    input  logic signed [mec_pkg::YAW_W-1:0]    yaw_rate,
    input  logic [mec_pkg::TIME_W-1:0]          now_ms,
    input  logic                                in_drive,
    input  logic                                clear_counts,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          event_code,
    output logic [mec_pkg::COUNT_W-1:0]         hard_brake_total,
    output logic [mec_pkg::COUNT_W-1:0]         hard_corner_total
);

    localparam int unsigned AW = mec_pkg::ACCEL_W;
    localparam int unsigned YW = mec_pkg::YAW_W;
    localparam int unsigned TW = mec_pkg::TIME_W;
    localparam int unsigned CW = mec_pkg::COUNT_W;
    localparam int unsigned HW = mec_pkg::THRESH_W;

    // configuration
    logic [HW-1:0]                     brake_thresh_reg;
    logic [HW-1:0]                     hard_brake_thresh_reg;
    logic [HW-1:0]                     bump_thresh_reg;
    logic [HW-1:0]                     corner_thresh_reg;
    logic [HW-1:0]                     hard_corner_thresh_reg;
    logic [mec_pkg::YAW_GATE_W-1:0]    yaw_gate_reg;
    logic [HW-1:0]                     accel_thresh_reg;
    logic [HW-1:0]                     cooldown_ms_reg;

    // input register
    logic                              s1_valid_reg;
    logic signed [AW-1:0]              s1_fwd_reg;
    logic signed [AW-1:0]              s1_lat_reg;
    logic signed [AW-1:0]              s1_vert_reg;
    logic signed [YW-1:0]              s1_yaw_reg;
    logic [TW-1:0]                     s1_now_reg;
    logic                              s1_drive_reg;
    logic                              s1_clr_reg;

    // event state
    logic [TW-1:0]                     last_brake_reg,  last_brake_next;
    logic [TW-1:0]                     last_bump_reg,   last_bump_next;
    logic [TW-1:0]                     last_corner_reg, last_corner_next;
    logic [TW-1:0]                     last_accel_reg,  last_accel_next;
    logic [CW-1:0]                     hb_count_reg,    hb_count_next;
    logic [CW-1:0]                     hc_count_reg,    hc_count_next;

    // output register
    logic                              out_valid_reg;
    mec_pkg::event_code_t              code_reg, code_next;

    logic                              out_free;
    logic                              s1_move;
    logic                              in_take;

    logic [AW-1:0]                     braking_mag;
    logic [AW-1:0]                     accel_mag;
    logic [AW-1:0]                     corner_mag;
    logic [AW-1:0]                     bump_mag;
    logic [YW-1:0]                     yaw_mag;
    logic                              turning;
    logic                              brake_hit;
    logic                              bump_hit;
    logic                              corner_hit;
    logic                              accel_hit;
    logic [CW-1:0]                     hb_base;
    logic [CW-1:0]                     hc_base;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    function automatic logic [AW-1:0] abs_val(input logic signed [AW-1:0] v);
        abs_val = v[AW-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb
    begin
        braking_mag = s1_fwd_reg[AW-1] ? abs_val(s1_fwd_reg) : '0;
        accel_mag   = s1_fwd_reg[AW-1] ? '0 : s1_fwd_reg;
        corner_mag  = abs_val(s1_lat_reg);
        bump_mag    = abs_val(s1_vert_reg);
        yaw_mag     = s1_yaw_reg[YW-1] ? (~s1_yaw_reg + 1'b1) : s1_yaw_reg;
        turning     = yaw_mag >= {1'b0, yaw_gate_reg};

        brake_hit  = (braking_mag >= {1'b0, brake_thresh_reg})
                     && ((s1_now_reg - last_brake_reg) >= {16'd0, cooldown_ms_reg});
        bump_hit   = (bump_mag >= {1'b0, bump_thresh_reg})
                     && ((s1_now_reg - last_bump_reg) >= {16'd0, cooldown_ms_reg});
        corner_hit = (corner_mag >= {1'b0, corner_thresh_reg}) && turning
                     && ((s1_now_reg - last_corner_reg) >= {16'd0, cooldown_ms_reg});
        accel_hit  = (accel_mag >= {1'b0, accel_thresh_reg})
                     && ((s1_now_reg - last_accel_reg) >= {16'd0, cooldown_ms_reg});

        hb_base = s1_clr_reg ? '0 : hb_count_reg;
        hc_base = s1_clr_reg ? '0 : hc_count_reg;

        last_brake_next  = last_brake_reg;
        last_bump_next   = last_bump_reg;
        last_corner_next = last_corner_reg;
        last_accel_next  = last_accel_reg;
        hb_count_next    = hb_base;
        hc_count_next    = hc_base;
        code_next        = mec_pkg::EV_NONE;

        if (brake_hit)
        begin
            last_brake_next = s1_now_reg;
            code_next       = mec_pkg::EV_BRAKE;
            if (s1_drive_reg && (braking_mag >= {1'b0, hard_brake_thresh_reg})
                && (hb_base != mec_pkg::COUNT_MAX))
            begin
                hb_count_next = hb_base + 1'b1;
            end
        end
        else if (bump_hit)
        begin
            last_bump_next = s1_now_reg;
            code_next      = mec_pkg::EV_BUMP;
        end
        else if (corner_hit)
        begin
            last_corner_next = s1_now_reg;
            code_next        = (!s1_yaw_reg[YW-1] && (s1_yaw_reg != '0))
                               ? mec_pkg::EV_CORNER_RIGHT : mec_pkg::EV_CORNER_LEFT;
            if (s1_drive_reg && (corner_mag >= {1'b0, hard_corner_thresh_reg})
                && (hc_base != mec_pkg::COUNT_MAX))
            begin
                hc_count_next = hc_base + 1'b1;
            end
        end
        else if (accel_hit)
        begin
            last_accel_next = s1_now_reg;
            code_next       = mec_pkg::EV_ACCEL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_thresh_reg       <= mec_pkg::BRAKE_RST;
            hard_brake_thresh_reg  <= mec_pkg::HARD_BRAKE_RST;
            bump_thresh_reg        <= mec_pkg::BUMP_RST;
            corner_thresh_reg      <= mec_pkg::CORNER_RST;
            hard_corner_thresh_reg <= mec_pkg::HARD_CORNER_RST;
            yaw_gate_reg           <= mec_pkg::YAW_GATE_RST;
            accel_thresh_reg       <= mec_pkg::ACCEL_RST;
            cooldown_ms_reg        <= mec_pkg::COOLDOWN_RST;
        end
        else if (cfg_we)
        begin
            case (mec_pkg::cfg_index_t'(cfg_index))
                mec_pkg::REG_BRAKE:       brake_thresh_reg       <= cfg_data;
                mec_pkg::REG_HARD_BRAKE:  hard_brake_thresh_reg  <= cfg_data;
                mec_pkg::REG_BUMP:        bump_thresh_reg        <= cfg_data;
                mec_pkg::REG_CORNER:      corner_thresh_reg      <= cfg_data;
                mec_pkg::REG_HARD_CORNER: hard_corner_thresh_reg <= cfg_data;
                mec_pkg::REG_YAW_GATE:    yaw_gate_reg <= cfg_data[mec_pkg::YAW_GATE_W-1:0];
                mec_pkg::REG_ACCEL:       accel_thresh_reg       <= cfg_data;
                mec_pkg::REG_COOLDOWN:    cooldown_ms_reg        <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_brake_reg  <= '0;
            last_bump_reg   <= '0;
            last_corner_reg <= '0;
            last_accel_reg  <= '0;
            hb_count_reg    <= '0;
            hc_count_reg    <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg   <= 1'b1;
                last_brake_reg  <= last_brake_next;
                last_bump_reg   <= last_bump_next;
                last_corner_reg <= last_corner_next;
                last_accel_reg  <= last_accel_next;
                hb_count_reg    <= hb_count_next;
                hc_count_reg    <= hc_count_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_fwd_reg   <= fwd_accel;
            s1_lat_reg   <= lat_accel;
            s1_vert_reg  <= vert_accel;
            s1_yaw_reg   <= yaw_rate;
            s1_now_reg   <= now_ms;
            s1_drive_reg <= in_drive;
            s1_clr_reg   <= clear_counts;
        end
        if (s1_move)
        begin
            code_reg <= code_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign event_code        = code_reg;
    assign hard_brake_total  = hb_count_reg;
    assign hard_corner_total = hc_count_reg;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for motion_event_classifier. Samples go through the
// valid/stall input port, and a scoreboard predicts the event code and the
// hard brake and hard corner totals for each accepted sample. Each result
// leaves through the output port and is compared against that prediction.
// The run covers directed corner cases and a burst of hard events. After
// that come random phases, each with its own register settings and one of
// four idling patterns.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SAT_ITEMS      = 40;
    localparam int PHASE_ITEMS    = 230;
    localparam int NUM_PHASES     = 8;

    typedef struct {
        mec_pkg::event_code_t        code;
        logic [mec_pkg::COUNT_W-1:0] brakes;
        logic [mec_pkg::COUNT_W-1:0] corners;
    } event_result_t;

    class event_scoreboard;
        logic [mec_pkg::THRESH_W-1:0] regs [8];
        logic [mec_pkg::TIME_W-1:0]   last_brake;
        logic [mec_pkg::TIME_W-1:0]   last_bump;
        logic [mec_pkg::TIME_W-1:0]   last_corner;
        logic [mec_pkg::TIME_W-1:0]   last_accel;
        logic [mec_pkg::COUNT_W-1:0]  brakes;
        logic [mec_pkg::COUNT_W-1:0]  corners;
        event_result_t                expected_events [$];
        int                           errors;

        function new();
            regs[mec_pkg::REG_BRAKE]       = mec_pkg::BRAKE_RST;
            regs[mec_pkg::REG_HARD_BRAKE]  = mec_pkg::HARD_BRAKE_RST;
            regs[mec_pkg::REG_BUMP]        = mec_pkg::BUMP_RST;
            regs[mec_pkg::REG_CORNER]      = mec_pkg::CORNER_RST;
            regs[mec_pkg::REG_HARD_CORNER] = mec_pkg::HARD_CORNER_RST;
            regs[mec_pkg::REG_YAW_GATE]    = {1'b0, mec_pkg::YAW_GATE_RST};
            regs[mec_pkg::REG_ACCEL]       = mec_pkg::ACCEL_RST;
            regs[mec_pkg::REG_COOLDOWN]    = mec_pkg::COOLDOWN_RST;
            last_brake  = '0;
            last_bump   = '0;
            last_corner = '0;
            last_accel  = '0;
            brakes      = '0;
            corners     = '0;
            errors      = 0;
        endfunction

        function void write_reg(mec_pkg::cfg_index_t idx,
                                logic [mec_pkg::CFG_DATA_W-1:0] val);
            if (idx == mec_pkg::REG_YAW_GATE)
                regs[idx] = {1'b0, val[mec_pkg::YAW_GATE_W-1:0]};
            else
                regs[idx] = val;
        endfunction

        function bit cooled(logic [mec_pkg::TIME_W-1:0] now,
                            logic [mec_pkg::TIME_W-1:0] last);
            logic [mec_pkg::TIME_W-1:0] gap;
            gap = now - last;
            return gap >= mec_pkg::TIME_W'(regs[mec_pkg::REG_COOLDOWN]);
        endfunction

        function void classify_sample(logic signed [mec_pkg::ACCEL_W-1:0] fwd,
                                      logic signed [mec_pkg::ACCEL_W-1:0] lat,
                                      logic signed [mec_pkg::ACCEL_W-1:0] vert,
                                      logic signed [mec_pkg::YAW_W-1:0]   yaw,
                                      logic [mec_pkg::TIME_W-1:0]         now,
                                      logic                               drive,
                                      logic                               clr);
            int            f;
            int            l;
            int            v;
            int            y;
            int            braking;
            int            accel;
            int            lat_mag;
            int            vert_mag;
            int            yaw_mag;
            bit            turning;
            event_result_t r;
            f        = int'(fwd);
            l        = int'(lat);
            v        = int'(vert);
            y        = int'(yaw);
            braking  = (f < 0) ? -f : 0;
            accel    = (f > 0) ? f : 0;
            lat_mag  = (l < 0) ? -l : l;
            vert_mag = (v < 0) ? -v : v;
            yaw_mag  = (y < 0) ? -y : y;
            turning  = yaw_mag >= int'(regs[mec_pkg::REG_YAW_GATE]);
            r.code   = mec_pkg::EV_NONE;
            if (clr)
            begin
                brakes  = '0;
                corners = '0;
            end
            if (braking >= int'(regs[mec_pkg::REG_BRAKE]) && cooled(now, last_brake))
            begin
                last_brake = now;
                if (drive && braking >= int'(regs[mec_pkg::REG_HARD_BRAKE])
                    && brakes != mec_pkg::COUNT_MAX)
                    brakes++;
                r.code = mec_pkg::EV_BRAKE;
            end
            else if (vert_mag >= int'(regs[mec_pkg::REG_BUMP]) && cooled(now, last_bump))
            begin
                last_bump = now;
                r.code    = mec_pkg::EV_BUMP;
            end
            else if (lat_mag >= int'(regs[mec_pkg::REG_CORNER]) && turning
                     && cooled(now, last_corner))
            begin
                last_corner = now;
                if (drive && lat_mag >= int'(regs[mec_pkg::REG_HARD_CORNER])
                    && corners != mec_pkg::COUNT_MAX)
                    corners++;
                r.code = (y > 0) ? mec_pkg::EV_CORNER_RIGHT : mec_pkg::EV_CORNER_LEFT;
            end
            else if (accel >= int'(regs[mec_pkg::REG_ACCEL]) && cooled(now, last_accel))
            begin
                last_accel = now;
                r.code     = mec_pkg::EV_ACCEL;
            end
            r.brakes  = brakes;
            r.corners = corners;
            expected_events.push_back(r);
        endfunction

        function void check_event(logic [2:0] code, logic [mec_pkg::COUNT_W-1:0] hb,
                                  logic [mec_pkg::COUNT_W-1:0] hc);
            event_result_t r;
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected result, event_code %0d", $time, code);
                errors++;
                return;
            end
            r = expected_events.pop_front();
            if (code !== r.code)
            begin
                $display("%0t: event_code expected %0d actual %0d", $time, r.code, code);
                errors++;
            end
            if (hb !== r.brakes)
            begin
                $display("%0t: hard_brake_total expected %0d actual %0d",
                         $time, r.brakes, hb);
                errors++;
            end
            if (hc !== r.corners)
            begin
                $display("%0t: hard_corner_total expected %0d actual %0d",
                         $time, r.corners, hc);
                errors++;
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_we;
    mec_pkg::cfg_index_t                cfg_index;
    logic [mec_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                               in_valid;
    logic                               in_stall;
    logic signed [mec_pkg::ACCEL_W-1:0] fwd_accel;
    logic signed [mec_pkg::ACCEL_W-1:0] lat_accel;
    logic signed [mec_pkg::ACCEL_W-1:0] vert_accel;
    logic signed [mec_pkg::YAW_W-1:0]   yaw_rate;
    logic [mec_pkg::TIME_W-1:0]         now_ms;
    logic                               in_drive;
    logic                               clear_counts;
    logic                               out_valid;
    logic                               out_stall;
    logic [2:0]                         event_code;
    logic [mec_pkg::COUNT_W-1:0]        hard_brake_total;
    logic [mec_pkg::COUNT_W-1:0]        hard_corner_total;

    event_scoreboard                    sb;
    int                                 send_idle_pct;
    int                                 stall_pct;
    bit                                 hold_req;
    logic [mec_pkg::TIME_W-1:0]         now_track;
    logic [mec_pkg::CFG_DATA_W-1:0]     cfg_next [8];

    motion_event_classifier u_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .fwd_accel         (fwd_accel),
        .lat_accel         (lat_accel),
        .vert_accel        (vert_accel),
        .yaw_rate          (yaw_rate),
        .now_ms            (now_ms),
        .in_drive          (in_drive),
        .clear_counts      (clear_counts),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .event_code        (event_code),
        .hard_brake_total  (hard_brake_total),
        .hard_corner_total (hard_corner_total)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.classify_sample(fwd_accel, lat_accel, vert_accel, yaw_rate, now_ms,
                               in_drive, clear_counts);
        if (rst_n && out_valid && !out_stall)
            sb.check_event(event_code, hard_brake_total, hard_corner_total);
    end

    // receiver side: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    task send_sample(input int f, input int l, input int v, input int y,
                     input logic [mec_pkg::TIME_W-1:0] t, input logic d, input logic c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        fwd_accel    <= mec_pkg::ACCEL_W'(f);
        lat_accel    <= mec_pkg::ACCEL_W'(l);
        vert_accel   <= mec_pkg::ACCEL_W'(v);
        yaw_rate     <= mec_pkg::YAW_W'(y);
        now_ms       <= t;
        in_drive     <= d;
        clear_counts <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function int rand_accel();
        int v;
        case ($urandom_range(0, 9))
            0: v = int'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       v = -65536;
                    1:       v = 65535;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            default: v = int'($urandom_range(0, 16000)) - 8000;
        endcase
        return v;
    endfunction

    function int rand_yaw();
        int v;
        case ($urandom_range(0, 9))
            0: v = int'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            default: v = int'($urandom_range(0, 1600)) - 800;
        endcase
        return v;
    endfunction

    task random_sample();
        case ($urandom_range(0, 29))
            0:       now_track = $urandom;
            1:       now_track = now_track - $urandom_range(1, 3000);
            default: now_track = now_track + $urandom_range(0, 1200);
        endcase
        send_sample(rand_accel(), rand_accel(), rand_accel(), rand_yaw(), now_track,
                    $urandom_range(0, 3) != 0, $urandom_range(0, 24) == 0);
    endtask

    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task fill_config(input logic [mec_pkg::CFG_DATA_W-1:0] v);
        foreach (cfg_next[i])
            cfg_next[i] = v;
    endtask

    task load_config();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= mec_pkg::cfg_index_t'(i);
            cfg_data  <= cfg_next[i];
            @(posedge clk);
            sb.write_reg(mec_pkg::cfg_index_t'(i), cfg_next[i]);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int l;
        int y;
        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = mec_pkg::REG_BRAKE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        fwd_accel     = '0;
        lat_accel     = '0;
        vert_accel    = '0;
        yaw_rate      = '0;
        now_ms        = '0;
        in_drive      = 1'b0;
        clear_counts  = 1'b0;
        send_idle_pct = 25;
        stall_pct     = 25;
        hold_req      = 1'b0;
        now_track     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds, cooldown 1500 ms
        send_sample(-65536, 0, 0, 0, 32'd1500, 1'b1, 1'b0);
        send_sample(-3000, 0, 3000, 0, 32'd1600, 1'b1, 1'b0);
        send_sample(0, 3000, 0, 200, 32'd1700, 1'b1, 1'b0);
        send_sample(0, -3000, 0, -200, 32'd1800, 1'b1, 1'b0);
        send_sample(65535, 0, 0, 0, 32'd1900, 1'b1, 1'b0);
        send_sample(0, -65536, 0, -32768, 32'd3300, 1'b1, 1'b0);
        send_sample(0, 2000, 0, 100, 32'd3400, 1'b1, 1'b0);
        send_sample(-4000, 0, 0, 0, 32'd3500, 1'b1, 1'b1);
        send_sample(-4000, 0, 0, 0, 32'd100, 1'b0, 1'b0);
        send_sample(0, 0, -65536, 0, 32'hFFFF_FF00, 1'b1, 1'b0);
        send_sample(0, 0, 65535, 0, 32'h0000_0100, 1'b1, 1'b0);
        send_sample(0, 0, 65535, 0, 32'h0000_0600, 1'b1, 1'b0);
        send_sample(0, 65535, 0, 32767, 32'h0000_0700, 1'b1, 1'b0);
        send_sample(-1, 1, -1, -1, 32'h0000_0800, 1'b0, 1'b0);

        // zero thresholds: zero magnitude still fires
        drain();
        fill_config('0);
        load_config();
        send_sample(5, 0, 0, 0, 32'd5000, 1'b1, 1'b0);
        send_sample(0, 0, 0, 0, 32'd5000, 1'b1, 1'b0);

        // corner fires at zero magnitude, zero yaw gives left; full-scale brake and bump still win
        drain();
        fill_config('1);
        cfg_next[mec_pkg::REG_CORNER]      = '0;
        cfg_next[mec_pkg::REG_HARD_CORNER] = '0;
        cfg_next[mec_pkg::REG_YAW_GATE]    = '0;
        cfg_next[mec_pkg::REG_ACCEL]       = '0;
        cfg_next[mec_pkg::REG_COOLDOWN]    = '0;
        load_config();
        send_sample(0, 0, 0, 0, 32'd6000, 1'b1, 1'b0);
        send_sample(0, 0, 0, 1, 32'd6001, 1'b1, 1'b0);
        send_sample(-65536, 0, 0, 0, 32'd6002, 1'b1, 1'b0);
        send_sample(0, 0, -65536, 0, 32'd6003, 1'b1, 1'b0);

        drain();
        fill_config('1);
        cfg_next[mec_pkg::REG_ACCEL]    = '0;
        cfg_next[mec_pkg::REG_COOLDOWN] = '0;
        load_config();
        send_sample(-3, 0, 0, 0, 32'd7000, 1'b1, 1'b0);

        // back to back hard brakes and hard corners
        drain();
        fill_config(16'd1);
        cfg_next[mec_pkg::REG_BUMP]     = '1;
        cfg_next[mec_pkg::REG_ACCEL]    = '1;
        cfg_next[mec_pkg::REG_COOLDOWN] = '0;
        load_config();
        send_idle_pct = 0;
        stall_pct     = 0;
        for (int k = 0; k < SAT_ITEMS; k++)
        begin
            now_track = now_track + $urandom_range(0, 50);
            if (k % 2 == 0)
                send_sample(-int'($urandom_range(1, 65536)), 0, 0, rand_yaw(), now_track,
                            1'b1, 1'b0);
            else
            begin
                l = int'($urandom_range(1, 65536));
                y = int'($urandom_range(1, 32767));
                if ($urandom_range(0, 1) == 1)
                    l = -l;
                if ($urandom_range(0, 1) == 1)
                    y = -y;
                send_sample(int'($urandom_range(0, 65535)), l, 0, y, now_track, 1'b1, 1'b0);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    cfg_next[mec_pkg::REG_BRAKE]       = mec_pkg::BRAKE_RST;
                    cfg_next[mec_pkg::REG_HARD_BRAKE]  = mec_pkg::HARD_BRAKE_RST;
                    cfg_next[mec_pkg::REG_BUMP]        = mec_pkg::BUMP_RST;
                    cfg_next[mec_pkg::REG_CORNER]      = mec_pkg::CORNER_RST;
                    cfg_next[mec_pkg::REG_HARD_CORNER] = mec_pkg::HARD_CORNER_RST;
                    cfg_next[mec_pkg::REG_YAW_GATE]    = {1'b0, mec_pkg::YAW_GATE_RST};
                    cfg_next[mec_pkg::REG_ACCEL]       = mec_pkg::ACCEL_RST;
                    cfg_next[mec_pkg::REG_COOLDOWN]    = mec_pkg::COOLDOWN_RST;
                end
                1: fill_config('1);
                3: fill_config('0);
                default:
                begin
                    foreach (cfg_next[i])
                    begin
                        if ($urandom_range(0, 7) == 0)
                            cfg_next[i] = mec_pkg::CFG_DATA_W'($urandom_range(0, 65535));
                        else
                            cfg_next[i] = mec_pkg::CFG_DATA_W'($urandom_range(0, 6000));
                    end
                    cfg_next[mec_pkg::REG_YAW_GATE] = {1'($urandom_range(0, 1)),
                                                       15'($urandom_range(0, 800))};
                    cfg_next[mec_pkg::REG_COOLDOWN] =
                        mec_pkg::CFG_DATA_W'($urandom_range(0, 3000));
                end
            endcase
            load_config();
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_req      = 1'b1;
                end
                1:
                begin
                    send_idle_pct = 84;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 84;
                end
                default:
                begin
                    send_idle_pct = 25;
                    stall_pct     = 25;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_sample();
        end

        drain();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ motion_event_classifier.f @@
rtl/mec_pkg.sv
rtl/motion_event_classifier.sv
dv/tb_top.sv
